[hdl/min_priority_queue_defines.svh]
// Assertion macros for the min_priority_queue RTL (used by mpq_ctrl).
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

// Generic form: explicit clock and active-low reset.
`define MPQ_ASSERT_ON(label, clock, resetn, prop, msg) \
  label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

// Common form for modules clocked by clk with reset rst_n.
`define MPQ_CHECK(label, prop, msg) \
  `MPQ_ASSERT_ON(label, clk, rst_n, prop, msg)

`endif

[hdl/mpq_pkg.sv]
// Types and constants of the min_priority_queue block.
package mpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int PRIO_W       = 16;
  localparam int PAYLOAD_W    = 16;
  localparam int COUNT_OUT_W  = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic                        op;
    logic signed [PRIO_W-1:0]    priority_req;
    logic        [PAYLOAD_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic                        out_valid;
    logic        [PAYLOAD_W-1:0] out_payload;
    logic signed [PRIO_W-1:0]    out_priority;
    logic                        was_empty;
    logic                        overflow;
    logic [COUNT_OUT_W-1:0]      count;
  } out_item_t;

  // One stored entry, as held in the RAM.
  typedef struct packed {
    logic signed [PRIO_W-1:0]    prio;
    logic        [PAYLOAD_W-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

[hdl/mpq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/mpq_ctrl.sv]
// Sequencer: push append, minimum scan and compaction over the entry RAM.
`include "min_priority_queue_defines.svh"

module mpq_ctrl #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
  localparam int ADDR_W  = $clog2(CAPACITY),
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mpq_pkg::in_item_t         in_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output mpq_pkg::out_item_t        res_data,
  output logic                      ram_we,
  output logic [ADDR_W-1:0]         ram_waddr,
  output logic [mpq_pkg::ENTRY_W-1:0] ram_wdata,
  output logic [ADDR_W-1:0]         ram_raddr,
  input  logic [mpq_pkg::ENTRY_W-1:0] ram_rdata
);

  mpq_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0]  best_idx_r, best_idx_nxt;
  mpq_pkg::entry_t    best_r, best_nxt;
  mpq_pkg::out_item_t res_r, res_nxt;

  mpq_pkg::entry_t    rd_entry, push_entry, scan_best;
  logic [ADDR_W-1:0]  last_idx, idx_inc, scan_idx;
  logic               take_new;

  assign rd_entry   = mpq_pkg::entry_t'(ram_rdata);
  assign last_idx   = ADDR_W'(count_r - CNT_W'(1));
  assign idx_inc    = ADDR_W'(idx_r + ADDR_W'(1));
  // strict less-than keeps the earliest entry on ties
  assign take_new   = (idx_r == '0) || (rd_entry.prio < best_r.prio);
  assign scan_idx   = take_new ? idx_r : best_idx_r;
  assign scan_best  = take_new ? rd_entry : best_r;
  assign push_entry = '{prio: in_data.priority_req, payload: in_data.payload};

  assign in_ready  = (state_r == mpq_pkg::ST_IDLE);
  assign res_valid = (state_r == mpq_pkg::ST_DONE);
  assign res_data  = res_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_waddr    = idx_r;
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_inc;
    case (state_r)
      mpq_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          if (in_data.op == mpq_pkg::OP_PUSH) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              res_nxt.overflow = 1'b1;
              res_nxt.count    = mpq_pkg::COUNT_OUT_W'(count_r);
            end else begin
              ram_we        = 1'b1;
              ram_waddr     = ADDR_W'(count_r);
              ram_wdata     = push_entry;
              count_nxt     = CNT_W'(count_r + CNT_W'(1));
              res_nxt.count = mpq_pkg::COUNT_OUT_W'(count_r + CNT_W'(1));
            end
            state_nxt = mpq_pkg::ST_DONE;
          end else if (count_r == '0) begin
            res_nxt.was_empty = 1'b1;
            state_nxt         = mpq_pkg::ST_DONE;
          end else begin
            ram_raddr = '0;
            idx_nxt   = '0;
            state_nxt = mpq_pkg::ST_SCAN;
          end
        end
      end
      mpq_pkg::ST_SCAN: begin
        best_idx_nxt = scan_idx;
        best_nxt     = scan_best;
        if (idx_r == last_idx) begin
          res_nxt              = '0;
          res_nxt.out_valid    = 1'b1;
          res_nxt.out_payload  = scan_best.payload;
          res_nxt.out_priority = scan_best.prio;
          res_nxt.count        = mpq_pkg::COUNT_OUT_W'(count_r - CNT_W'(1));
          if (scan_idx == last_idx) begin
            count_nxt = CNT_W'(count_r - CNT_W'(1));
            state_nxt = mpq_pkg::ST_DONE;
          end else begin
            // close the gap: fetch the entry behind the winner
            ram_raddr = ADDR_W'(scan_idx + ADDR_W'(1));
            idx_nxt   = scan_idx;
            state_nxt = mpq_pkg::ST_SHIFT;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end
      mpq_pkg::ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        if (idx_inc == last_idx) begin
          count_nxt = CNT_W'(count_r - CNT_W'(1));
          state_nxt = mpq_pkg::ST_DONE;
        end else begin
          ram_raddr = ADDR_W'(idx_inc + ADDR_W'(1));
          idx_nxt   = idx_inc;
        end
      end
      mpq_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = mpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpq_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
  end

  `MPQ_CHECK(a_count_bound, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `MPQ_CHECK(a_push_grows, (in_valid && in_ready && in_data.op == mpq_pkg::OP_PUSH && count_r != CNT_W'(CAPACITY)) |=> (count_r == CNT_W'($past(count_r) + CNT_W'(1))), "accepted push did not add an entry")
  `MPQ_CHECK(a_write_state, ram_we |-> (state_r == mpq_pkg::ST_IDLE || state_r == mpq_pkg::ST_SHIFT), "RAM write outside push or compaction")
  `MPQ_CHECK(a_shift_no_overlap, (state_r == mpq_pkg::ST_SHIFT) |-> (ram_raddr != ram_waddr), "compaction reads the entry it writes")

endmodule

[hdl/min_priority_queue.sv]
// Top level of the min_priority_queue block: entry RAM, sequencer, result register.
//
// Bounded min-priority queue of CAPACITY entries (signed 16-bit priority,
// 16-bit handle). A push appends behind all held entries; a pop removes the
// smallest priority, the earliest arrival winning ties, and the rest keep
// their order. Each transfer in gives exactly one transfer out carrying the
// count after the item, with was_empty on a pop of an empty queue and
// overflow on a push to a full one (that push is dropped). Entries live in
// one RAM with a registered read, so timing is set by its single read
// port: a push or an empty/overflow item goes straight to the result; a
// pop scans the held entries (one entry per cycle), then compacts those
// behind the winner (one move per cycle), then gives its result.
// in_ready is high only while the sequencer is idle. The result sits in
// an output register, so a new item is taken while an earlier result
// still waits for out_ready.
module min_priority_queue #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mpq_pkg::out_item_t out_data
);

  localparam int ADDR_W = $clog2(CAPACITY);

  logic                        res_valid, res_ready;
  mpq_pkg::out_item_t          res_data;
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
  logic [mpq_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic                        out_valid_r, out_valid_nxt;
  mpq_pkg::out_item_t          out_data_r, out_data_nxt;

  mpq_ram #(
    .WIDTH (mpq_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output slot frees up on the cycle its transfer completes
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sim/tb_min_priority_queue.sv]
// Self-checking testbench for min_priority_queue: directed and random push/pop traffic.
`timescale 1ns / 100ps

module tb_min_priority_queue;

  localparam int QCAP        = mpq_pkg::CAPACITY_DEF;
  localparam int RAND_ITEMS  = 400;
  // Receiver freezes once this many results are in, long enough for the
  // output register and the sequencer to back up into in_ready.
  localparam int LONG_HOLD_AT  = 150;
  localparam int LONG_HOLD_LEN = 300;
  // Extra wait after the last result is in, before the run ends.
  localparam int TAIL_CYCLES = 4 * QCAP + 8;

  // Traffic mix of one random run: lean toward filling, draining, or neither.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  // One queued request; hold_till_drained makes the sender wait until every
  // earlier result has come back before it offers this one.
  typedef struct {
    mpq_pkg::in_item_t item;
    bit                hold_till_drained;
  } req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  mpq_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  mpq_pkg::out_item_t out_data;

  // Stimulus and scoreboard
  req_t               req_q[$];
  mpq_pkg::out_item_t pending_results[$];
  int                 n_sent = 0;     // input transfers, updated by NBA only
  int                 n_recv = 0;     // output transfers, updated by NBA only
  int                 n_total;
  int                 err_count = 0;

  // Shadow copy of the queue contents, in arrival order
  logic signed [mpq_pkg::PRIO_W-1:0]    held_prio[QCAP];
  logic        [mpq_pkg::PAYLOAD_W-1:0] held_pay[QCAP];
  int                                   held_n = 0;

  // Sender / receiver pacing
  int                 gap_left = 0;
  int                 stall_left = 0;
  bit                 long_hold_done = 0;
  bit                 took;
  int                 pace_r;
  int                 pace_rx;
  req_t               nxt_req;
  mpq_pkg::out_item_t want;

  min_priority_queue #(.CAPACITY(QCAP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the shadow queue and returns the result it must
  // produce: push appends, pop takes the smallest priority (earliest on a
  // tie) and closes the hole, full push and empty pop only flag.
  function automatic mpq_pkg::out_item_t pq_apply(mpq_pkg::in_item_t req);
    mpq_pkg::out_item_t res;
    int                 win;
    res = '0;
    if (req.op == mpq_pkg::OP_PUSH) begin
      if (held_n >= QCAP) begin
        res.overflow = 1'b1;
      end else begin
        held_prio[held_n] = req.priority_req;
        held_pay[held_n]  = req.payload;
        held_n++;
      end
    end else if (held_n == 0) begin
      res.was_empty = 1'b1;
    end else begin
      win = 0;
      for (int i = 1; i < held_n; i++)
        if (held_prio[i] < held_prio[win]) win = i;   // strict: first one wins ties
      res.out_valid    = 1'b1;
      res.out_payload  = held_pay[win];
      res.out_priority = held_prio[win];
      for (int i = win; i + 1 < held_n; i++) begin
        held_prio[i] = held_prio[i + 1];
        held_pay[i]  = held_pay[i + 1];
      end
      held_n--;
    end
    res.count = mpq_pkg::COUNT_OUT_W'(held_n);
    return res;
  endfunction

  task automatic queue_req(logic op, int prio, int pay, bit hold);
    req_t r;
    r.item.op           = op;
    r.item.priority_req = mpq_pkg::PRIO_W'(prio);
    r.item.payload      = mpq_pkg::PAYLOAD_W'(pay);
    r.hold_till_drained = hold;
    req_q.push_back(r);
  endtask

  task automatic compare_field(string fname, int exp_v, int act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      err_count++;
    end
  endtask

  // Sender. Prediction happens at the accepting edge, so the expectation is
  // queued well before its result can leave the output register.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        pending_results.push_back(pq_apply(in_data));
        n_sent <= n_sent + 1;
        // Every fourth stretch of 50 transfers runs back to back.
        pace_r = $urandom_range(0, 99);
        if ((n_sent / 50) % 4 == 3 || pace_r < 50) gap_left = 0;
        else if (pace_r < 90) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(10, 40);
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0 &&
                     (!req_q[0].hold_till_drained || (!took && n_recv == n_sent))) begin
          nxt_req = req_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= nxt_req.item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_recv <= n_recv + 1;
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: %p", out_data);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("out_valid", want.out_valid, out_data.out_valid);
          compare_field("out_payload", want.out_payload, out_data.out_payload);
          compare_field("out_priority", int'(want.out_priority),
                        int'(out_data.out_priority));
          compare_field("was_empty", want.was_empty, out_data.was_empty);
          compare_field("overflow", want.overflow, out_data.overflow);
          compare_field("count", want.count, out_data.count);
        end
      end
      if (n_recv == LONG_HOLD_AT && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ((n_recv / 64) % 3 == 2) begin
        out_ready <= 1'b1;                 // no back-pressure in this stretch
      end else begin
        pace_rx = $urandom_range(0, 99);
        if (pace_rx < 75) begin
          out_ready <= 1'b1;
        end else begin
          stall_left = (pace_rx < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    mix_t mix;
    int   run_len;
    int   n_rand;
    int   r;
    int   p;
    bit   is_pop;

    // Directed: empty pop, a full load with extreme priorities and ties,
    // a dropped push on the full queue, then pops that must come out by
    // priority with ties in arrival order.
    queue_req(mpq_pkg::OP_POP, 0, 0, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 0, 'h1234, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 32767, 'hFFFF, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, -32768, 'h0000, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 5, 'hA5A5, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, -32768, 'h0001, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 5, 'h5A5A, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, -1, 'h8000, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 0, 'h7FFF, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, -1, 'h00FF, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 1, 'hFF00, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 100, 'h0F0F, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, -100, 'hF0F0, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 32767, 'h3333, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 32766, 'hCCCC, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, -32767, 'h5555, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 5, 'hAAAA, 1'b0);
    queue_req(mpq_pkg::OP_PUSH, 7, 'hDEAD, 1'b0);   // queue is full: dropped
    for (int k = 0; k < 7; k++)
      queue_req(mpq_pkg::OP_POP, 0, 0, 1'b0);

    // Random runs that push toward full, toward empty, or stay balanced.
    // Priorities lean on a narrow band so ties are common.
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      mix = mix_t'($urandom_range(0, 2));
      run_len = $urandom_range(15, 40);
      for (int k = 0; k < run_len && n_rand < RAND_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  is_pop = (r >= 80);
          MIX_DRAIN: is_pop = (r >= 25);
          default:   is_pop = (r >= 50);
        endcase
        r = $urandom_range(0, 99);
        if (r < 40) begin
          p = int'($urandom_range(0, 8)) - 4;
        end else if (r < 55) begin
          case ($urandom_range(0, 3))
            0:       p = -32768;
            1:       p = 32767;
            2:       p = -1;
            default: p = 0;
          endcase
        end else begin
          p = $urandom_range(0, 65535);
        end
        queue_req(is_pop ? mpq_pkg::OP_POP : mpq_pkg::OP_PUSH, p,
                  $urandom_range(0, 65535), n_rand % 100 == 0);
        n_rand++;
      end
    end
    n_total = req_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_sent == n_total);
    wait (n_recv == n_sent);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_min_priority_queue: done, clean");
    end else begin
      $display("tb_min_priority_queue: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("tb_min_priority_queue: done, errors");
    $finish;
  end

endmodule
